@@ rtl/assert_macros.svh @@
// Assertion macros shared by the path MTU cache RTL.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define PMC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define PMC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/pmc_pkg.sv @@
`timescale 1ns / 1ps
// Package for the path MTU cache: sizes, opcodes, register indexes and the
// scan, request and write-command types passed between the cells and the core.
package pmc_pkg;

  localparam int ENTRIES = 16;
  // wide enough for any entry index in the supported range (up to 256 entries)
  localparam int IDX_W   = 8;

  localparam logic [1:0] OP_LOOKUP = 2'd0;
  localparam logic [1:0] OP_UPDATE = 2'd1;
  localparam logic [1:0] OP_FLUSH  = 2'd2;

  localparam logic REG_MIN_MTU  = 1'b0;
  localparam logic REG_LIFETIME = 1'b1;

  localparam logic [15:0] MIN_MTU_RST  = 16'd68;
  localparam logic [39:0] LIFETIME_RST = 40'd600000000000;

  // Record that walks down the chain, one cell per cycle.
  typedef struct packed {
    logic             valid;
    logic             matched;
    logic [IDX_W-1:0] match_idx;
    logic             match_live;
    logic [15:0]      match_mtu;
    logic             have_free;
    logic [IDX_W-1:0] free_idx;
    logic [IDX_W-1:0] oldest_idx;
    logic [63:0]      oldest_exp;
  } scan_t;

  // Operands held by the core for the whole scan.
  typedef struct packed {
    logic [31:0] dest;
    logic [63:0] now;
  } req_t;

  // Write command broadcast to every cell at the end of a scan.
  typedef struct packed {
    logic             flush;
    logic             wr_exp;
    logic             wr_dest;
    logic             wr_mtu;
    logic [IDX_W-1:0] idx;
    logic [15:0]      mtu;
    logic [63:0]      exp;
  } cmd_t;

endpackage

@@ rtl/pmc_cell.sv @@
`timescale 1ns / 1ps
// One cache entry with its stage of the scan chain.
// Depends on pmc_pkg for the scan, request and command types.
module pmc_cell #(
  parameter int IDX = 0
) (
  input  logic           clk,
  input  logic           rst_n,
  input  pmc_pkg::req_t  req,
  input  pmc_pkg::scan_t scan_in,
  input  pmc_pkg::cmd_t  cmd,
  output pmc_pkg::scan_t scan_out
);

  localparam logic [pmc_pkg::IDX_W-1:0] MY_IDX = IDX[pmc_pkg::IDX_W-1:0];

  logic [31:0]    dest_r;
  logic [15:0]    mtu_r;
  logic [63:0]    exp_r;
  pmc_pkg::scan_t scan_r;
  pmc_pkg::scan_t scan_nxt;

  logic in_use;
  logic is_match;
  logic is_dead;

  assign in_use   = (exp_r != 64'd0);
  assign is_match = in_use && (dest_r == req.dest);
  assign is_dead  = !in_use || (req.now >= exp_r);

  always_comb begin
    scan_nxt = scan_in;
    // first match stops the search; later cells pass the record through
    if (!scan_in.matched) begin
      if (is_match) begin
        scan_nxt.matched    = 1'b1;
        scan_nxt.match_idx  = MY_IDX;
        scan_nxt.match_live = (req.now < exp_r);
        scan_nxt.match_mtu  = mtu_r;
      end else if (is_dead) begin
        if (!scan_in.have_free) begin
          scan_nxt.have_free = 1'b1;
          scan_nxt.free_idx  = MY_IDX;
        end
      end else if (exp_r < scan_in.oldest_exp) begin
        scan_nxt.oldest_exp = exp_r;
        scan_nxt.oldest_idx = MY_IDX;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_r.valid <= 1'b0;
    end else begin
      scan_r.valid <= scan_in.valid;
    end
    if (scan_in.valid) begin
      scan_r.matched    <= scan_nxt.matched;
      scan_r.match_idx  <= scan_nxt.match_idx;
      scan_r.match_live <= scan_nxt.match_live;
      scan_r.match_mtu  <= scan_nxt.match_mtu;
      scan_r.have_free  <= scan_nxt.have_free;
      scan_r.free_idx   <= scan_nxt.free_idx;
      scan_r.oldest_idx <= scan_nxt.oldest_idx;
      scan_r.oldest_exp <= scan_nxt.oldest_exp;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.flush) begin
      dest_r <= 32'd0;
      mtu_r  <= 16'd0;
      exp_r  <= 64'd0;
    end else if (cmd.idx == MY_IDX) begin
      if (cmd.wr_exp) begin
        exp_r <= cmd.exp;
      end
      if (cmd.wr_dest) begin
        dest_r <= req.dest;
      end
      if (cmd.wr_mtu) begin
        mtu_r <= cmd.mtu;
      end
    end
  end

  assign scan_out = scan_r;

endmodule

@@ rtl/path_mtu_cache_core.sv @@
`timescale 1ns / 1ps
// Path MTU cache: ENTRIES cells in a chain, one command at a time.
// The start transfer is registered into the seed record, the scan record
// steps one cell per cycle through each cell's register, then the write commits.
// A new command is taken only once the last is done; busy falls with out_valid.
// Synchronous reset frees every entry and loads the register defaults.
// Results are never stalled: out_valid is high for exactly one cycle.
`include "assert_macros.svh"
module path_mtu_cache_core #(
  parameter int ENTRIES = pmc_pkg::ENTRIES
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_operation,
  input  logic [31:0] in_dest_addr,
  input  logic [15:0] in_new_mtu,
  input  logic [63:0] in_now_ns,
  output logic        out_valid,
  output logic [15:0] out_found_mtu,
  output logic        out_hit,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [39:0] cfg_wdata
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  logic        state_r;
  logic        state_nxt;
  logic        seed_vld_r;
  logic [15:0] min_mtu_r;
  logic [39:0] lifetime_r;
  logic [1:0]  op_r;
  logic [15:0] mtu_r;
  logic [63:0] exp_r;
  logic        out_valid_r;
  logic [15:0] out_found_r;
  logic        out_hit_r;

  pmc_pkg::req_t  req_r;
  pmc_pkg::scan_t seed;
  pmc_pkg::scan_t chain [ENTRIES+1];
  pmc_pkg::scan_t fin;
  pmc_pkg::cmd_t  cmd;

  logic        accept;
  logic [64:0] exp_sum;
  logic [15:0] mtu_clamped;
  logic        hit_c;

  assign accept      = start && (state_r == ST_IDLE);
  assign busy        = (state_r == ST_SCAN);
  assign exp_sum     = {1'b0, in_now_ns} + {25'd0, lifetime_r};
  assign mtu_clamped = (in_new_mtu < min_mtu_r) ? min_mtu_r : in_new_mtu;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_mtu_r  <= pmc_pkg::MIN_MTU_RST;
      lifetime_r <= pmc_pkg::LIFETIME_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        pmc_pkg::REG_MIN_MTU:  min_mtu_r  <= cfg_wdata[15:0];
        pmc_pkg::REG_LIFETIME: lifetime_r <= cfg_wdata;
        default:               min_mtu_r  <= min_mtu_r;
      endcase
    end
  end

  // hold the operands for the whole scan
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r       <= in_operation;
      req_r.dest <= in_dest_addr;
      req_r.now  <= in_now_ns;
      mtu_r      <= mtu_clamped;
      exp_r      <= exp_sum[64] ? {64{1'b1}} : exp_sum[63:0];
    end
  end

  always_comb begin
    seed            = '0;
    seed.valid      = seed_vld_r;
    seed.oldest_exp = {64{1'b1}};
  end

  assign chain[0] = seed;

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    pmc_cell #(
      .IDX (g)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .req      (req_r),
      .scan_in  (chain[g]),
      .cmd      (cmd),
      .scan_out (chain[g+1])
    );
  end

  assign fin   = chain[ENTRIES];
  assign hit_c = fin.matched && fin.match_live;

  // build the commit from the record leaving the last cell
  always_comb begin
    cmd     = '0;
    cmd.mtu = mtu_r;
    cmd.exp = exp_r;
    if (fin.valid) begin
      case (op_r)
        pmc_pkg::OP_LOOKUP: begin
          // drop an expired match
          cmd.idx    = fin.match_idx;
          cmd.wr_exp = fin.matched && !fin.match_live;
          cmd.exp    = 64'd0;
        end
        pmc_pkg::OP_UPDATE: begin
          cmd.idx     = fin.matched ? fin.match_idx :
                        (fin.have_free ? fin.free_idx : fin.oldest_idx);
          cmd.wr_exp  = 1'b1;
          cmd.wr_dest = 1'b1;
          cmd.wr_mtu  = !fin.matched || !fin.match_live || (mtu_r < fin.match_mtu);
        end
        pmc_pkg::OP_FLUSH: begin
          cmd.flush = 1'b1;
        end
        default: begin
          cmd.flush = 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (accept) begin
        state_nxt = ST_SCAN;
      end
      ST_SCAN: if (fin.valid) begin
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      seed_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      seed_vld_r  <= accept;
      out_valid_r <= fin.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fin.valid) begin
      out_hit_r   <= (op_r == pmc_pkg::OP_LOOKUP) && hit_c;
      out_found_r <= ((op_r == pmc_pkg::OP_LOOKUP) && hit_c) ? fin.match_mtu : 16'd0;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_found_mtu = out_found_r;
  assign out_hit       = out_hit_r;

  `PMC_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "busy did not rise after a transfer")
  `PMC_ASSERT_NEXT(a_chain_result, fin.valid, out_valid, "scan ended without a result")
  `PMC_ASSERT_NOW(a_result_idle, out_valid, !busy, "result shown while still busy")
  `PMC_ASSERT_NOW(a_miss_zero, out_valid && !out_hit, out_found_mtu == 16'd0,
                  "nonzero MTU without a hit")

endmodule
